@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define MCF_ASSERT_NOW(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("mcf assertion failed");

// property holds in the next cycle
`define MCF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("mcf assertion failed");

`endif

@@ src/mcf_pkg.sv @@
// shared types and constants of the motor command frame serializer
`default_nettype none
package mcf_pkg;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0]  DEV_ADDR_RST = 8'd128;

	// frame kinds
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_ONE   = 3'd1;
	localparam logic [2:0] CMD_FOUR  = 3'd2;
	localparam logic [2:0] CMD_EIGHT = 3'd3;
	localparam logic [2:0] CMD_SIXT  = 3'd4;
	localparam logic [2:0] CMD_BARE  = 3'd5;

	// address, opcode, up to 16 payload bytes and the flag byte
	localparam int DATA_BYTES = 19;
	localparam int DATA_W     = DATA_BYTES * 8;
	localparam int IDX_W      = 5;

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic       clear;
		logic       fold;
		logic [7:0] data;
	} crc_ctl_t;

endpackage
`default_nettype wire

@@ src/motor_cmd_frame_crc16_serializer.sv @@
// top level of the motor command frame serializer with crc-16
//
// usage
// - request channel: a frame request is taken at a clock edge with start high and
//   busy low; command, opcode, word0..word3 and buffer_flag are sampled there
// - command picks the frame kind: 0 no payload (4 bytes), 1 low byte of word0 (5),
//   2 word0 (8), 3 word0 and word1 (12), 4 all four words plus flag byte (21),
//   5 bare read request (2 bytes, no crc); kinds 6 and 7 send nothing
// - result channel: one frame byte per cycle on tx_byte, marked by strobe for one
//   cycle; last is high on the final byte; the receiver cannot stall the stream
// - config channel: cfg_data is the device address, written when cfg_valid and
//   cfg_ready are high; cfg_ready is low while a frame is being sent
// - timing: the first byte reaches the ports through the output register, then one
//   byte per cycle follows; busy is high while a frame is being sent, and a new request
//   is taken only when busy is low, so the block takes no new request before the
//   sequencer has sent the current frame
// - crc is xmodem style (poly 0x1021, init 0), sent high byte first
// - reset: device address returns to 128, the sequencer idles and no strobe shows
`default_nettype none
module motor_cmd_frame_crc16_serializer (
	input  wire         clk,
	input  wire         arst_n,
	// request channel
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  command,
	input  wire  [7:0]  opcode,
	input  wire  [31:0] word0,
	input  wire  [31:0] word1,
	input  wire  [31:0] word2,
	input  wire  [31:0] word3,
	input  wire         buffer_flag,
	// byte stream out
	output logic        strobe,
	output logic [7:0]  tx_byte,
	output logic        last,
	// device address write channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_data
);
	import mcf_pkg::*;

	logic [7:0]   dev_addr_q;
	logic         strobe_q;
	logic [7:0]   tx_byte_q;
	logic         last_q;

	logic         seq_valid;
	logic [7:0]   seq_byte;
	logic         seq_last;
	logic [15:0]  crc;
	crc_ctl_t     crc_ctl;

	// address may only change between frames
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RST;
		end else if (cfg_valid && cfg_ready) begin
			dev_addr_q <= cfg_data;
		end
	end

	// sequencer walks the frame, one byte per cycle
	mcf_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.command        (command),
		.opcode         (opcode),
		.word0          (word0),
		.word1          (word1),
		.word2          (word2),
		.word3          (word3),
		.buffer_flag    (buffer_flag),
		.device_address (dev_addr_q),
		.crc            (crc),
		.busy           (busy),
		.out_valid      (seq_valid),
		.out_byte       (seq_byte),
		.out_last       (seq_last),
		.crc_ctl        (crc_ctl)
	);

	// crc unit, cleared when a frame is loaded and fed every data byte
	mcf_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc)
	);

	// output register decouples the stream from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= seq_valid;
			last_q   <= seq_valid && seq_last;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_valid) begin
			tx_byte_q <= seq_byte;
		end
	end

	assign strobe  = strobe_q;
	assign tx_byte = tx_byte_q;
	assign last    = last_q;

endmodule
`default_nettype wire

@@ src/mcf_crc.sv @@
// crc-16 unit, folds one byte per cycle while fold is high
`default_nettype none
module mcf_crc (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire mcf_pkg::crc_ctl_t ctl,
	output logic [15:0]          crc
);
	import mcf_pkg::*;

	logic [15:0] crc_q;
	logic [15:0] crc_next;

	always_comb begin
		logic [15:0] c;
		c = crc_q ^ {ctl.data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_next = c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (ctl.clear) begin
			crc_q <= '0;
		end else if (ctl.fold) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;

endmodule
`default_nettype wire

@@ src/mcf_seq.sv @@
// frame sequencer: loads a request, steps through bytes, drives the crc unit
`default_nettype none
module mcf_seq (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire  [2:0]              command,
	input  wire  [7:0]              opcode,
	input  wire  [31:0]             word0,
	input  wire  [31:0]             word1,
	input  wire  [31:0]             word2,
	input  wire  [31:0]             word3,
	input  wire                     buffer_flag,
	input  wire  [7:0]              device_address,
	input  wire  [15:0]             crc,
	output logic                    busy,
	output logic                    out_valid,
	output logic [7:0]              out_byte,
	output logic                    out_last,
	output mcf_pkg::crc_ctl_t       crc_ctl
);
	import mcf_pkg::*;

	state_t                 state_q, state_d;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       len_q;
	logic [IDX_W-1:0]       data_len_q;
	logic [DATA_W-1:0]      data_q;

	logic                   accept;
	logic                   load;
	logic [DATA_W-1:0]      load_data;
	logic [IDX_W-1:0]       load_len;
	logic [IDX_W-1:0]       load_data_len;

	// byte image and lengths of each frame kind
	always_comb begin
		load_data     = '0;
		load_len      = '0;
		load_data_len = '0;
		unique case (command)
			CMD_NONE: begin
				load_data     = {device_address, opcode, 136'd0};
				load_data_len = 5'd2;
				load_len      = 5'd4;
			end
			CMD_ONE: begin
				load_data     = {device_address, opcode, word0[7:0], 128'd0};
				load_data_len = 5'd3;
				load_len      = 5'd5;
			end
			CMD_FOUR: begin
				load_data     = {device_address, opcode, word0, 104'd0};
				load_data_len = 5'd6;
				load_len      = 5'd8;
			end
			CMD_EIGHT: begin
				load_data     = {device_address, opcode, word0, word1, 72'd0};
				load_data_len = 5'd10;
				load_len      = 5'd12;
			end
			CMD_SIXT: begin
				load_data     = {device_address, opcode, word0, word1, word2, word3,
					7'd0, buffer_flag};
				load_data_len = 5'd19;
				load_len      = 5'd21;
			end
			CMD_BARE: begin
				load_data     = {device_address, opcode, 136'd0};
				load_data_len = 5'd2;
				load_len      = 5'd2;
			end
			default: begin
				load_data     = '0;
				load_data_len = '0;
				load_len      = '0;
			end
		endcase
	end

	assign accept = start && (state_q == ST_IDLE);
	assign load   = accept && (command <= CMD_BARE);

	always_comb begin
		state_d       = state_q;
		out_valid     = 1'b0;
		out_byte      = '0;
		out_last      = 1'b0;
		crc_ctl.clear = load;
		crc_ctl.fold  = 1'b0;
		crc_ctl.data  = data_q[DATA_W-1 -: 8];
		unique case (state_q)
			ST_IDLE: begin
				if (load) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				out_valid = 1'b1;
				out_last  = (idx_q == len_q - 5'd1);
				if (idx_q < data_len_q) begin
					out_byte     = data_q[DATA_W-1 -: 8];
					crc_ctl.fold = 1'b1;
				end else if (idx_q == data_len_q) begin
					out_byte = crc[15:8];
				end else begin
					out_byte = crc[7:0];
				end
				if (out_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			len_q      <= '0;
			data_len_q <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				idx_q      <= '0;
				len_q      <= load_len;
				data_len_q <= load_data_len;
			end else if (state_q == ST_SEND) begin
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (state_q == ST_SEND) begin
			data_q <= {data_q[DATA_W-9:0], 8'h00};
		end
	end

	assign busy = (state_q == ST_SEND);

endmodule
`default_nettype wire

@@ src/mcf_checker.sv @@
// port-level checker for the motor command frame serializer
`default_nettype none
`include "assert_macros.svh"
module mcf_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire [2:0]  command,
	input wire        strobe,
	input wire        last,
	input wire        cfg_valid,
	input wire        cfg_ready
);
	import mcf_pkg::*;

	logic req_ok;
	logic cfg_seen;

	assign req_ok   = start && !busy && (command <= CMD_BARE);
	assign cfg_seen = cfg_valid && cfg_ready;

	// a valid request starts a frame
	`MCF_ASSERT_NEXT(a_req_busy, clk, arst_n, req_ok, busy)
	// last only on a strobed byte
	`MCF_ASSERT_NOW(a_last_strobe, clk, arst_n, last, strobe)
	// frames are not sent back to back on the stream
	`MCF_ASSERT_NEXT(a_last_gap, clk, arst_n, last, !strobe)
	// end of busy coincides with the final byte
	`MCF_ASSERT_NOW(a_end_last, clk, arst_n, $fell(busy), last)
	// no address write during a frame
	`MCF_ASSERT_NOW(a_cfg_idle, clk, arst_n, cfg_seen, !busy)

endmodule

bind motor_cmd_frame_crc16_serializer mcf_checker u_mcf_checker (.*);
`default_nettype wire
